// ----- rtl/echo_pulse_ranger_with_mode_bands_top_macros.svh -----
// Assertion macros for the echo pulse ranger.
`ifndef ECHO_PULSE_RANGER_WITH_MODE_BANDS_TOP_MACROS_SVH
`define ECHO_PULSE_RANGER_WITH_MODE_BANDS_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define EPR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define EPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EPR_ASSERT(lbl, clk, rst, prop, msg)
`define EPR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/epr_pkg.sv -----
package epr_pkg;

   localparam int CFG_BITS  = 16;
   localparam int DIST_BITS = 20;
   localparam int IDX_BITS  = 3;

   // ticks * 170 / 1000 reduced to ticks * 17 / 100
   localparam int SOUND_NUM = 170;
   localparam int SOUND_DEN = 1000;
   localparam int SOUND_GCD = 10;
   localparam int STEP_NUM  = SOUND_NUM / SOUND_GCD;
   localparam int STEP_DEN  = SOUND_DEN / SOUND_GCD;
   localparam int REM_BITS  = $clog2(STEP_DEN);

   typedef logic [CFG_BITS-1:0]  cfg_type;
   typedef logic [DIST_BITS-1:0] dist_type;
   typedef logic [REM_BITS-1:0]  rem_type;
   typedef logic [REM_BITS:0]    rem_sum_type;
   typedef logic [IDX_BITS-1:0]  idx_type;

   localparam dist_type DIST_MAX = '1;

   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_READ     = 2'd1,
      CMD_CLASSIFY = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_NONE   = 2'd0,
      MODE_STOP   = 2'd1,
      MODE_AVOID  = 2'd2,
      MODE_FOLLOW = 2'd3
   } mode_type;

   localparam idx_type REG_AVOID_MIN  = 3'd0;
   localparam idx_type REG_AVOID_MAX  = 3'd1;
   localparam idx_type REG_FOLLOW_MIN = 3'd2;
   localparam idx_type REG_FOLLOW_MAX = 3'd3;

endpackage

// ----- rtl/echo_pulse_ranger_with_mode_bands_top.sv -----
// Echo pulse ranger with mode bands.
// Input channel (req_*): one word per item; req_cmd selects a microsecond tick
// carrying the sampled echo level, a distance read, or a band classification.
// Result channel (rsp_*): exactly one word per accepted item, in order, with the
// kept distance in millimetres, a fresh flag and a mode update code.
// Config port (csr_*): plain write of the four band bounds, index 0..3; other
// indexes are dropped. Write only while no word is in flight.
// The result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle unless stalled. The state update and the result
// are one level of logic from the state registers into the result register; the
// millimetre conversion is kept as a running quotient and remainder of
// ticks*17/100 that moves by at most one each tick, so a read costs no divider.
// Stall: while rsp_ready is low a held result blocks req_ready; the word is
// taken the same cycle the result register drains, so no bubble is added.
// Reset (synchronous, active high): capture goes idle, counters and distance
// clear, band bounds return to 20/100/240/300 mm, the result register empties.
`include "echo_pulse_ranger_with_mode_bands_top_macros.svh"

module echo_pulse_ranger_with_mode_bands_top #(
   parameter int OVERFLOW_BITS = 6,
   parameter int TIMER_BITS    = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_cmd,
   input  logic                           req_echo_level,
   input  logic                           req_mode_eligible,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [epr_pkg::DIST_BITS-1:0]  rsp_distance_mm,
   output logic                           rsp_distance_fresh,
   output logic [1:0]                     rsp_mode_update,
   input  logic                           csr_we,
   input  logic [epr_pkg::IDX_BITS-1:0]   csr_index,
   input  logic [epr_pkg::CFG_BITS-1:0]   csr_wdata
);

   localparam int TICK_BITS = OVERFLOW_BITS + TIMER_BITS;
   localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_COUNT = 2'd1,
      PH_HELD  = 2'd2
   } phase_type;

   // band bounds
   epr_pkg::cfg_type avoid_min_ff, avoid_max_ff, follow_min_ff, follow_max_ff;

   // capture state
   logic                   echo_prev_ff, echo_prev_in;
   phase_type              phase_ff, phase_in;
   logic [TICK_BITS-1:0]   ticks_ff, ticks_in;
   epr_pkg::dist_type      quot_ff, quot_in;   // floor(ticks*17/100), capped
   epr_pkg::rem_type       rem_ff, rem_in;     // ticks*17 mod 100
   epr_pkg::dist_type      dist_ff, dist_in;

   // result register
   logic                   rsp_valid_ff;
   epr_pkg::dist_type      rsp_dist_ff;
   logic                   rsp_fresh_ff, rsp_fresh_in;
   epr_pkg::mode_type      rsp_mode_ff, rsp_mode_in;

   logic                   accept;
   epr_pkg::cmd_type       cmd;
   epr_pkg::rem_sum_type   rem_sum;
   logic                   rise, fall;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign cmd       = epr_pkg::cmd_type'(req_cmd);

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_distance_mm    = rsp_dist_ff;
   assign rsp_distance_fresh = rsp_fresh_ff;
   assign rsp_mode_update    = rsp_mode_ff;

   assign rise    = req_echo_level && !echo_prev_ff;
   assign fall    = !req_echo_level && echo_prev_ff;
   assign rem_sum = {1'b0, rem_ff} + epr_pkg::rem_sum_type'(epr_pkg::STEP_NUM);

   always_comb begin
      echo_prev_in = echo_prev_ff;
      phase_in     = phase_ff;
      ticks_in     = ticks_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      dist_in      = dist_ff;
      rsp_fresh_in = 1'b0;
      rsp_mode_in  = epr_pkg::MODE_NONE;
      case (cmd)
         epr_pkg::CMD_TICK: begin
            echo_prev_in = req_echo_level;
            unique case (phase_ff)
               PH_IDLE: begin
                  if (rise) begin
                     ticks_in = '0;
                     quot_in  = '0;
                     rem_in   = '0;
                     phase_in = PH_COUNT;
                  end
               end
               PH_COUNT: begin
                  if (ticks_ff != TICK_MAX) begin
                     ticks_in = ticks_ff + 1'b1;
                     if (rem_sum >= epr_pkg::rem_sum_type'(epr_pkg::STEP_DEN)) begin
                        rem_in = epr_pkg::REM_BITS'(rem_sum -
                                 epr_pkg::rem_sum_type'(epr_pkg::STEP_DEN));
                        if (quot_ff != epr_pkg::DIST_MAX) quot_in = quot_ff + 1'b1;
                     end else begin
                        rem_in = epr_pkg::REM_BITS'(rem_sum);
                     end
                  end
                  if (fall) phase_in = PH_HELD;
               end
               PH_HELD: ;
               default: phase_in = PH_IDLE;
            endcase
         end
         epr_pkg::CMD_READ: begin
            if (phase_ff == PH_HELD) begin
               dist_in      = quot_ff;
               phase_in     = PH_IDLE;
               rsp_fresh_in = 1'b1;
            end
         end
         epr_pkg::CMD_CLASSIFY: begin
            if (req_mode_eligible && dist_ff != '0) begin
               if (dist_ff > epr_pkg::DIST_BITS'(avoid_min_ff) &&
                   dist_ff < epr_pkg::DIST_BITS'(avoid_max_ff))
                  rsp_mode_in = epr_pkg::MODE_AVOID;
               else if (dist_ff > epr_pkg::DIST_BITS'(follow_min_ff) &&
                        dist_ff < epr_pkg::DIST_BITS'(follow_max_ff))
                  rsp_mode_in = epr_pkg::MODE_FOLLOW;
               else
                  rsp_mode_in = epr_pkg::MODE_STOP;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avoid_min_ff  <= 16'd20;
         avoid_max_ff  <= 16'd100;
         follow_min_ff <= 16'd240;
         follow_max_ff <= 16'd300;
      end else if (csr_we) begin
         unique case (csr_index)
            epr_pkg::REG_AVOID_MIN:  avoid_min_ff  <= csr_wdata;
            epr_pkg::REG_AVOID_MAX:  avoid_max_ff  <= csr_wdata;
            epr_pkg::REG_FOLLOW_MIN: follow_min_ff <= csr_wdata;
            epr_pkg::REG_FOLLOW_MAX: follow_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_prev_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         ticks_ff     <= '0;
         quot_ff      <= '0;
         rem_ff       <= '0;
         dist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            echo_prev_ff <= echo_prev_in;
            phase_ff     <= phase_in;
            ticks_ff     <= ticks_in;
            quot_ff      <= quot_in;
            rem_ff       <= rem_in;
            dist_ff      <= dist_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, loaded with each accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_dist_ff  <= dist_in;
         rsp_fresh_ff <= rsp_fresh_in;
         rsp_mode_ff  <= rsp_mode_in;
      end
   end

   `EPR_ASSERT(a_rem_range, clock, reset,
      rem_ff < epr_pkg::rem_type'(epr_pkg::STEP_DEN), "remainder out of range")
   `EPR_ASSERT(a_read_rearms, clock, reset,
      accept && cmd == epr_pkg::CMD_READ && phase_ff == PH_HELD |=>
         phase_ff == PH_IDLE && rsp_distance_fresh && rsp_distance_mm == $past(quot_ff),
      "read of held capture did not re-arm")
   `EPR_ASSERT(a_tick_count, clock, reset,
      accept && cmd == epr_pkg::CMD_TICK && phase_ff == PH_COUNT && ticks_ff != TICK_MAX |=>
         ticks_ff == $past(ticks_ff) + 1'b1, "pulse counter missed a tick")
   `EPR_ASSERT(a_fresh_excl, clock, reset,
      rsp_valid_ff && rsp_fresh_ff |-> rsp_mode_ff == epr_pkg::MODE_NONE,
      "fresh flag with mode update")
   `EPR_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> !rsp_valid_ff && phase_ff == PH_IDLE, "reset left state busy")

endmodule
